[rtl/core/sti_pkg.sv]
`default_nettype none
package sti_pkg;

  localparam int DATA_W          = 32;
  localparam int INDEX_W         = 6;
  localparam int COUNT_W         = 7;
  localparam int TABLE_DEPTH_DEF = 64;

  // Magnitudes of differences of two data words, and their exact product.
  localparam int MAG_W  = DATA_W + 1;
  localparam int PROD_W = 2 * MAG_W;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage
`default_nettype wire

[rtl/core/sti_if.sv]
`default_nettype none
interface sti_req_if;
  import sti_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [INDEX_W-1:0]        point_index;
  logic signed [DATA_W-1:0]  point_x;
  logic signed [DATA_W-1:0]  point_y;
  logic signed [DATA_W-1:0]  query_x;
  logic                      query_last;

  modport source (output valid, func, point_index, point_x, point_y, query_x, query_last,
                  input ready);
  modport sink (input valid, func, point_index, point_x, point_y, query_x, query_last,
                output ready);
endinterface

interface sti_rsp_if;
  import sti_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  value;
  logic                      out_of_range;
  logic                      batch_last;

  modport source (output valid, value, out_of_range, batch_last, input ready);
  modport sink (input valid, value, out_of_range, batch_last, output ready);
endinterface

interface sti_cfg_if;
  import sti_pkg::*;
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  point_count;

  modport source (output valid, point_count, input ready);
  modport sink (input valid, point_count, output ready);
endinterface
`default_nettype wire

[rtl/core/sti_ram.sv]
`default_nettype none
module sti_ram #(
  parameter int WIDTH = 2 * sti_pkg::DATA_W,
  parameter int DEPTH = sti_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/core/sti_muldiv.sv]
`default_nettype none
module sti_muldiv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sti_pkg::MAG_W-1:0]  mag,
  input  logic [sti_pkg::MAG_W-1:0]  dq,
  input  logic [sti_pkg::MAG_W-1:0]  den,
  output logic                       done,
  output logic [sti_pkg::MAG_W-1:0]  quot
);
  import sti_pkg::*;

  localparam int LO_W   = (MAG_W + 1) / 2;
  localparam int PP_W   = MAG_W + LO_W;
  localparam int STEP_W = $clog2(MAG_W);

  typedef enum logic [1:0] {MD_IDLE, MD_MUL_LO, MD_MUL_HI, MD_DIV} md_state_t;

  md_state_t          state;
  logic [STEP_W-1:0]  step;
  logic [PROD_W-1:0]  acc;
  logic [LO_W-1:0]    mul_b;
  logic [PP_W-1:0]    prod;
  logic [MAG_W:0]     trial;

  // One narrow multiplier serves both halves of the multiplier operand.
  assign mul_b = (state == MD_MUL_HI) ? LO_W'(dq[MAG_W-1:LO_W]) : dq[LO_W-1:0];
  assign prod  = PP_W'(mag) * PP_W'(mul_b);

  // Restoring division: the upper half of acc is the partial remainder, the
  // lower half shifts dividend bits out and quotient bits in.
  assign trial = {acc[PROD_W-1:MAG_W], acc[MAG_W-1]} - {1'b0, den};
  assign quot  = acc[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        MD_IDLE: begin
          if (start) begin
            state <= MD_MUL_LO;
          end
        end
        MD_MUL_LO: begin
          state <= MD_MUL_HI;
        end
        MD_MUL_HI: begin
          state <= MD_DIV;
          step  <= '0;
        end
        MD_DIV: begin
          if (step == STEP_W'(MAG_W - 1)) begin
            state <= MD_IDLE;
            done  <= 1'b1;
          end
          step <= step + STEP_W'(1);
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MD_MUL_LO: acc <= PROD_W'(prod);
      MD_MUL_HI: acc <= acc + (PROD_W'(prod) << LO_W);
      MD_DIV: begin
        if (!trial[MAG_W]) begin
          acc <= {trial[MAG_W-1:0], acc[MAG_W-2:0], 1'b1};
        end else begin
          acc <= {acc[PROD_W-2:0], 1'b0};
        end
      end
      default: acc <= acc;
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/sorted_table_linear_interpolator_top.sv]
`default_nettype none
// Channel  Dir  Payload                                               Accepted when
// req      in   func, point_index, point_x, point_y, query_x, query_last  valid && ready
// rsp      out  value, out_of_range, batch_last                       valid && ready
// cfg      in   point_count                                           valid && ready
//
// A load word is written to the table RAM when it is accepted. A query that
// falls outside the table or on an end point is settled against the two end
// points; otherwise the linear search reads one breakpoint per cycle from the
// table RAM, then a shared 33x17 multiplier and a one-bit-per-cycle restoring
// divider form the interpolated value. Reset is synchronous and sets the
// point count to 2; the tables are not cleared. req is held off while a query
// is in flight; a finished result waits in the output register, and the next
// word is taken meanwhile.
module sorted_table_linear_interpolator_top #(
  parameter int TABLE_DEPTH = sti_pkg::TABLE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  sti_req_if.sink   req,
  sti_rsp_if.source rsp,
  sti_cfg_if.sink   cfg
);
  import sti_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST, S_LAST, S_SRCH, S_PREP, S_WAIT, S_DONE
  } state_t;

  state_t                    state;
  logic [COUNT_W-1:0]        point_count;
  logic [AW-1:0]             last_idx;
  logic [AW-1:0]             n;
  logic signed [DATA_W-1:0]  q;
  logic                      q_last;
  logic signed [DATA_W-1:0]  xa;
  logic signed [DATA_W-1:0]  ya;
  logic signed [DATA_W-1:0]  xb;
  logic signed [DATA_W-1:0]  yb;
  logic signed [DATA_W-1:0]  res_value;
  logic                      res_oor;
  logic [MAG_W-1:0]          mag;
  logic [MAG_W-1:0]          dq;
  logic [MAG_W-1:0]          den;
  logic                      dy_neg;

  logic                      req_acc;
  logic                      ram_we;
  logic [AW-1:0]             ram_raddr;
  logic [2*DATA_W-1:0]       ram_rdata;
  logic signed [DATA_W-1:0]  rd_x;
  logic signed [DATA_W-1:0]  rd_y;
  logic signed [MAG_W-1:0]   dy_w;
  logic                      md_done;
  logic [MAG_W-1:0]          md_quot;

  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign ram_we = req_acc && (req.func == FUNC_LOAD) &&
                  (32'(req.point_index) < TABLE_DEPTH);

  assign rd_x = ram_rdata[2*DATA_W-1:DATA_W];
  assign rd_y = ram_rdata[DATA_W-1:0];

  always_comb begin
    if (point_count < COUNT_W'(2)) begin
      last_idx = AW'(1);
    end else if (32'(point_count) > TABLE_DEPTH) begin
      last_idx = AW'(TABLE_DEPTH - 1);
    end else begin
      last_idx = AW'(point_count - COUNT_W'(1));
    end
  end

  // The read address is set in the state before the one that uses its data,
  // since the RAM output is registered.
  always_comb begin
    case (state)
      S_FIRST: ram_raddr = last_idx;
      S_LAST:  ram_raddr = AW'(1);
      S_SRCH:  ram_raddr = n + AW'(1);
      default: ram_raddr = '0;
    endcase
  end

  assign dy_w = $signed({yb[DATA_W-1], yb}) - $signed({ya[DATA_W-1], ya});

  sti_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(req.point_index)),
    .wdata ({req.point_x, req.point_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sti_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_PREP),
    .mag   (mag),
    .dq    (dq),
    .den   (den),
    .done  (md_done),
    .quot  (md_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      point_count <= cfg.point_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      // In S_DONE the output register is refilled or left alone below.
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc && (req.func == FUNC_QUERY)) begin
            q      <= req.query_x;
            q_last <= req.query_last;
            state  <= S_FIRST;
          end
        end
        S_FIRST: begin
          xa    <= rd_x;
          ya    <= rd_y;
          state <= S_LAST;
        end
        S_LAST: begin
          if (q < xa || q > rd_x) begin
            res_oor   <= 1'b1;
            res_value <= '0;
            state     <= S_DONE;
          end else if (q == rd_x) begin
            res_oor   <= 1'b0;
            res_value <= rd_y;
            state     <= S_DONE;
          end else if (q == xa) begin
            res_oor   <= 1'b0;
            res_value <= ya;
            state     <= S_DONE;
          end else begin
            res_oor <= 1'b0;
            n       <= AW'(1);
            state   <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (n < last_idx && rd_x <= q) begin
            xa <= rd_x;
            ya <= rd_y;
            n  <= n + AW'(1);
          end else begin
            xb    <= rd_x;
            yb    <= rd_y;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (md_done) begin
            if (dy_neg) begin
              res_value <= ya - md_quot[DATA_W-1:0];
            end else begin
              res_value <= ya + md_quot[DATA_W-1:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.value        <= res_value;
            rsp.out_of_range <= res_oor;
            rsp.batch_last   <= q_last;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Operands for the shared unit: |y1 - y0|, q - x0 and x1 - x0, all
  // non-negative within the chosen interval.
  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      dy_neg <= dy_w[MAG_W-1];
      mag    <= dy_w[MAG_W-1] ? MAG_W'(-dy_w) : MAG_W'(dy_w);
      dq     <= {q[DATA_W-1], q} - {xa[DATA_W-1], xa};
      den    <= {xb[DATA_W-1], xb} - {xa[DATA_W-1], xa};
    end
  end
endmodule
`default_nettype wire
